@@ hw/rtl/stcf_pkg.sv @@
// Shared types and constants of the sample table crossfade block.
`timescale 1ns / 1ps
`default_nettype none

package stcf_pkg;

	localparam int MAX_CHUNKS_DEF = 16;
	localparam int FIFO_DEPTH     = 4;
	localparam int DIV_QW         = 24;

	localparam logic [16:0] ONE_Q16    = 17'd65536;
	localparam logic [23:0] PITCH_SAT  = 24'hFFFFFF;
	localparam logic [23:0] PT_MAX     = 24'hFFFFFF;
	localparam logic [23:0] PT_CAP_LOW = 24'd25344;
	localparam logic [15:0] PITCH_ONE  = 16'd4096;
	localparam logic [6:0]  CF_MAX     = 7'd100;

	localparam logic OP_WRITE = 1'b0;

	localparam logic [1:0] CFG_CROSSFADE = 2'd0;
	localparam logic [1:0] CFG_COUNT     = 2'd1;
	localparam logic [1:0] CFG_FLOOR     = 2'd2;

	typedef enum logic [1:0] {
		K_WRITE,
		K_BOOKEND,
		K_OUTSIDE,
		K_EVAL
	} kind_t;

	typedef enum logic [1:0] {
		FR_ONE,
		FR_ZERO,
		FR_DIV
	} frac_t;

	// word handed from front to back
	typedef struct packed {
		kind_t       kind;
		logic [3:0]  chunk_index;
		logic        write_ok;
		logic        first;
		logic        has_next;
		logic [15:0] threshold;
		logic [15:0] pitch;
		logic        has_sample;
		logic [23:0] point;
	} item_t;

	// result controls carried alongside the dividers
	typedef struct packed {
		kind_t kind;
		logic  act;
		logic  pf_one;
		logic  pf_sat;
		logic  g_full;
		logic  g_inv;
		frac_t frac;
	} side_t;

endpackage

`default_nettype wire

@@ hw/rtl/stcf_if.sv @@
// Channel interfaces: item input, result output and configuration write.
`timescale 1ns / 1ps
`default_nettype none

interface stcf_item_if;
	logic        valid;
	logic        ready;
	logic        op;
	logic [3:0]  chunk_index;
	logic [15:0] threshold;
	logic [15:0] chunk_pitch;
	logic        has_sample;
	logic        is_bookend;
	logic [31:0] control_value;

	modport source (output valid, op, chunk_index, threshold, chunk_pitch, has_sample,
		is_bookend, control_value, input ready);
	modport sink (input valid, op, chunk_index, threshold, chunk_pitch, has_sample,
		is_bookend, control_value, output ready);
endinterface

interface stcf_result_if;
	logic        valid;
	logic        ready;
	logic        active;
	logic [23:0] pitch_factor;
	logic [16:0] gain_factor;

	modport source (output valid, active, pitch_factor, gain_factor, input ready);
	modport sink (input valid, active, pitch_factor, gain_factor, output ready);
endinterface

interface stcf_cfg_if;
	logic        valid;
	logic        ready;
	logic [1:0]  index;
	logic [15:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/sample_table_crossfade_top.sv @@
// Top level of the sample table crossfade block.
//
//  channel  dir  words                         handshake
//  items    in   table write / chunk evaluate  valid, ready
//  results  out  active, pitch, gain           valid, ready
//  cfg      in   register index, data          valid, ready (always ready)
//
// One word is taken per cycle while the queue has room; every item gives
// exactly one result word, through the front register, queue, four back
// stages, 24 stages of the pitch and gain dividers and result register.
// Reset initialises control state and clears the has-sample flags;
// thresholds and pitches hold nothing until written. A stalled result
// freezes the back pipeline while the front keeps filling the queue.
`timescale 1ns / 1ps
`default_nettype none

module sample_table_crossfade_top #(
	parameter int MAX_CHUNKS = stcf_pkg::MAX_CHUNKS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	stcf_item_if.sink     items,
	stcf_result_if.source results,
	stcf_cfg_if.sink      cfg
);

	logic [6:0]  cf_q, cf_eff;
	logic [4:0]  count_q;
	logic [15:0] floor_q;

	assign cfg.ready = 1'b1;
	assign cf_eff    = (cf_q > stcf_pkg::CF_MAX) ? stcf_pkg::CF_MAX : cf_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cf_q    <= '0;
			count_q <= 5'd1;
			floor_q <= '0;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				stcf_pkg::CFG_CROSSFADE: cf_q    <= cfg.data[6:0];
				stcf_pkg::CFG_COUNT:     count_q <= cfg.data[4:0];
				stcf_pkg::CFG_FLOOR:     floor_q <= cfg.data;
				default: begin
				end
			endcase
		end
	end

	logic            push, full, pop, empty;
	stcf_pkg::item_t f_word, q_word;

	stcf_front #(.MAX_CHUNKS(MAX_CHUNKS)) u_front (
		.clk(clk), .arst_n(arst_n), .items(items), .chunk_count(count_q),
		.push_ok(!full), .push(push), .word(f_word)
	);

	stcf_fifo u_fifo (
		.clk(clk), .arst_n(arst_n), .push(push), .din(f_word), .full(full),
		.pop(pop), .dout(q_word), .empty(empty)
	);

	stcf_back #(.MAX_CHUNKS(MAX_CHUNKS)) u_back (
		.clk(clk), .arst_n(arst_n), .head(q_word), .empty(empty), .pop(pop),
		.cf(cf_eff), .floor_pt(floor_q), .results(results)
	);

	// gain never exceeds unity
	a_gain_range: assert property (@(posedge clk) disable iff (!arst_n)
		results.valid |-> results.gain_factor <= stcf_pkg::ONE_Q16)
		else $error("gain above one");

	// evaluations never give a zero pitch, so a zero pitch marks a write word
	a_write_word: assert property (@(posedge clk) disable iff (!arst_n)
		results.valid && results.pitch_factor == 24'd0
		|-> !results.active && results.gain_factor == 17'd0)
		else $error("write word with nonzero fields");

	// the queue is never pushed while full
	a_queue: assert property (@(posedge clk) disable iff (!arst_n)
		full && !pop |=> !(push && $past(full)) || pop)
		else $error("queue overrun");

endmodule

`default_nettype wire

@@ hw/rtl/stcf_front.sv @@
// Front: accepts items, forms the sound point and classifies each word.
`timescale 1ns / 1ps
`default_nettype none

module stcf_front #(
	parameter int MAX_CHUNKS = stcf_pkg::MAX_CHUNKS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	stcf_item_if.sink        items,
	input  logic [4:0]       chunk_count,
	input  logic             push_ok,
	output logic             push,
	output stcf_pkg::item_t  word
);

	localparam int XW = $clog2(MAX_CHUNKS + 32);

	logic              vld_s1;
	stcf_pkg::item_t   word_s1;
	stcf_pkg::item_t   word_c;
	logic signed [31:0] c;
	logic [37:0]       prod;
	logic [29:0]       p_raw;
	logic [XW-1:0]     cnt_x, max_x, n_x, idx_x;

	assign c     = $signed(items.control_value);
	assign prod  = 38'(c[30:0]) * 38'd100;
	assign p_raw = prod[37:8];

	assign cnt_x = XW'(chunk_count);
	assign max_x = XW'(MAX_CHUNKS);
	assign idx_x = XW'(items.chunk_index);

	always_comb begin
		if (cnt_x == '0) begin
			n_x = XW'(1);
		end else if (cnt_x > max_x) begin
			n_x = max_x;
		end else begin
			n_x = cnt_x;
		end

		word_c             = '0;
		word_c.chunk_index = items.chunk_index;
		word_c.threshold   = items.threshold;
		word_c.pitch       = items.chunk_pitch;
		word_c.has_sample  = items.has_sample;
		word_c.write_ok    = idx_x < max_x;
		word_c.first       = items.chunk_index == 4'd0;
		word_c.has_next    = (idx_x + XW'(1)) < n_x;

		if (c <= 32'sd0) begin
			word_c.point = '0;
		end else if (c <= 32'sd65536) begin
			word_c.point = (p_raw > 30'(stcf_pkg::PT_CAP_LOW)) ? stcf_pkg::PT_CAP_LOW
				: p_raw[23:0];
		end else begin
			word_c.point = (p_raw > 30'(stcf_pkg::PT_MAX)) ? stcf_pkg::PT_MAX : p_raw[23:0];
		end

		if (items.op == stcf_pkg::OP_WRITE) begin
			word_c.kind = stcf_pkg::K_WRITE;
		end else if (items.is_bookend) begin
			word_c.kind = stcf_pkg::K_BOOKEND;
		end else if (idx_x >= n_x) begin
			word_c.kind = stcf_pkg::K_OUTSIDE;
		end else begin
			word_c.kind = stcf_pkg::K_EVAL;
		end
	end

	assign push        = vld_s1 && push_ok;
	assign items.ready = !vld_s1 || push_ok;
	assign word        = word_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (items.ready) begin
			vld_s1 <= items.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (items.ready && items.valid) begin
			word_s1 <= word_c;
		end
	end

endmodule

`default_nettype wire

@@ hw/rtl/stcf_fifo.sv @@
// Short word queue between front and back.
`timescale 1ns / 1ps
`default_nettype none

module stcf_fifo (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  stcf_pkg::item_t  din,
	output logic             full,
	input  logic             pop,
	output stcf_pkg::item_t  dout,
	output logic             empty
);

	localparam int PW = $clog2(stcf_pkg::FIFO_DEPTH);

	stcf_pkg::item_t mem_q [stcf_pkg::FIFO_DEPTH];
	logic [PW-1:0]   wr_q, rd_q;
	logic [PW:0]     cnt_q;

	assign full  = cnt_q == (PW+1)'(stcf_pkg::FIFO_DEPTH);
	assign empty = cnt_q == '0;
	assign dout  = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + PW'(1);
			end
			if (pop) begin
				rd_q <= rd_q + PW'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + (PW+1)'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - (PW+1)'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= din;
		end
	end

endmodule

`default_nettype wire

@@ hw/rtl/stcf_div.sv @@
// Pipelined restoring divider, one quotient bit per stage.
`timescale 1ns / 1ps
`default_nettype none

module stcf_div #(
	parameter int NUM_W = 56,
	parameter int DEN_W = 40,
	parameter int Q_W   = 24
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             vld_in,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic             vld_out,
	output logic [Q_W-1:0]   quo
);

	// caller guarantees num < den << Q_W
	localparam int W = DEN_W + Q_W;

	logic [W-1:0]     rem_s [Q_W-1];
	logic [DEN_W-1:0] den_s [Q_W-1];
	logic [Q_W-1:0]   q_s   [Q_W];
	logic [Q_W-1:0]   vld_s;

	genvar k;
	generate
		for (k = 0; k < Q_W; k++) begin : g_stage
			localparam int SH = Q_W - 1 - k;
			logic [W-1:0]     rem_in, shifted, rem_nx;
			logic [DEN_W-1:0] den_in;
			logic [Q_W-1:0]   q_in;
			logic             v_in, ge;

			if (k == 0) begin : g_first
				assign rem_in = W'(num);
				assign den_in = den;
				assign q_in   = '0;
				assign v_in   = vld_in;
			end else begin : g_rest
				assign rem_in = rem_s[k-1];
				assign den_in = den_s[k-1];
				assign q_in   = q_s[k-1];
				assign v_in   = vld_s[k-1];
			end

			assign shifted = W'(den_in) << SH;
			assign ge      = rem_in >= shifted;
			assign rem_nx  = ge ? rem_in - shifted : rem_in;

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					vld_s[k] <= 1'b0;
				end else if (en) begin
					vld_s[k] <= v_in;
				end
			end

			always_ff @(posedge clk) begin
				if (en) begin
					q_s[k] <= {q_in[Q_W-2:0], ge};
				end
			end

			if (k < Q_W - 1) begin : g_keep
				always_ff @(posedge clk) begin
					if (en) begin
						rem_s[k] <= rem_nx;
						den_s[k] <= den_in;
					end
				end
			end
		end
	endgenerate

	assign vld_out = vld_s[Q_W-1];
	assign quo     = q_s[Q_W-1];

endmodule

`default_nettype wire

@@ hw/rtl/stcf_back.sv @@
// Back: table storage, fade and pitch arithmetic, dividers and result register.
`timescale 1ns / 1ps
`default_nettype none

module stcf_back #(
	parameter int MAX_CHUNKS = stcf_pkg::MAX_CHUNKS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  stcf_pkg::item_t  head,
	input  logic             empty,
	output logic             pop,
	input  logic [6:0]       cf,
	input  logic [15:0]      floor_pt,
	stcf_result_if.source    results
);

	localparam int IDX_W = $clog2(MAX_CHUNKS);
	localparam int QW    = stcf_pkg::DIV_QW;

	logic en, wr;
	logic [IDX_W-1:0] a_prev, a_cur, a_next;

	// ---------------- stage 1: table read ----------------
	logic [31:0] mem_p [MAX_CHUNKS];
	logic [31:0] mem_c [MAX_CHUNKS];
	logic [31:0] mem_n [MAX_CHUNKS];
	logic [MAX_CHUNKS-1:0] hs_q;

	logic                vld_s1, first_s1, next_s1, hs_s1;
	stcf_pkg::kind_t     kind_s1;
	logic [23:0]         point_s1;
	logic [31:0]         rp_s1, rc_s1, rn_s1;

	assign en     = !results.valid || results.ready;
	assign pop    = en && !empty;
	assign wr     = pop && head.kind == stcf_pkg::K_WRITE && head.write_ok;
	assign a_cur  = IDX_W'(head.chunk_index);
	assign a_prev = IDX_W'(head.chunk_index - 4'd1);
	assign a_next = IDX_W'({1'b0, head.chunk_index} + 5'd1);

	always_ff @(posedge clk) begin
		if (wr) begin
			mem_p[a_cur] <= {head.threshold, head.pitch};
			mem_c[a_cur] <= {head.threshold, head.pitch};
			mem_n[a_cur] <= {head.threshold, head.pitch};
		end
		if (en) begin
			rp_s1    <= mem_p[a_prev];
			rc_s1    <= mem_c[a_cur];
			rn_s1    <= mem_n[a_next];
			hs_s1    <= hs_q[a_cur];
			kind_s1  <= head.kind;
			first_s1 <= head.first;
			next_s1  <= head.has_next;
			point_s1 <= head.point;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hs_q   <= '0;
			vld_s1 <= 1'b0;
		end else begin
			if (wr) begin
				hs_q[a_cur] <= head.has_sample;
			end
			if (en) begin
				vld_s1 <= pop;
			end
		end
	end

	// ---------------- stage 2: differences, pitch setup ----------------
	logic [15:0] tp, tc, tn, pp, pc, pn, ppv, pcv, pnv, fo_base;
	logic signed [16:0] d1, d2;
	logic signed [24:0] cfd1_c, cfd2_c, num_a, num_b, den_a, den_b, num_p, den_p;
	logic [22:0] tc100_c, tn100_c, fo100_c;
	logic [30:0] ps_c;
	logic below_c, sel_a, sel_b, den_pos;
	logic [23:0] u_c, d_c;

	assign tp = rp_s1[31:16];
	assign pp = rp_s1[15:0];
	assign tc = rc_s1[31:16];
	assign pc = rc_s1[15:0];
	assign tn = rn_s1[31:16];
	assign pn = rn_s1[15:0];
	assign ppv = (pp == '0) ? stcf_pkg::PITCH_ONE : pp;
	assign pcv = (pc == '0) ? stcf_pkg::PITCH_ONE : pc;
	assign pnv = (pn == '0) ? stcf_pkg::PITCH_ONE : pn;

	always_comb begin
		d1      = $signed({1'b0, tc}) - $signed({1'b0, tp});
		d2      = $signed({1'b0, tn}) - $signed({1'b0, tc});
		cfd1_c  = $signed({1'b0, cf}) * d1;
		cfd2_c  = $signed({1'b0, cf}) * d2;
		tc100_c = 23'(tc) * 23'd100;
		tn100_c = 23'(tn) * 23'd100;
		fo_base = next_s1 ? tn : ((floor_pt > tc) ? floor_pt : tc);
		fo100_c = 23'(fo_base) * 23'd100;
		ps_c    = 31'(point_s1) * 31'd100;
		below_c = point_s1 < {tc, 8'h00};
		sel_a   = below_c && !first_s1;
		sel_b   = !below_c && next_s1;
		num_a   = $signed({1'b0, point_s1}) - $signed({1'b0, tp, 8'h00});
		num_b   = $signed({1'b0, point_s1}) - $signed({1'b0, tc, 8'h00});
		den_a   = $signed({d1, 8'h00});
		den_b   = $signed({d2, 8'h00});
		num_p   = sel_a ? num_a : num_b;
		den_p   = sel_a ? den_a : den_b;
		den_pos = den_p > 25'sd0;
		if (num_p < 25'sd0) begin
			u_c = '0;
		end else if (num_p > den_p) begin
			u_c = den_p[23:0];
		end else begin
			u_c = num_p[23:0];
		end
		d_c = den_p[23:0];
	end

	logic                vld_s2, first_s2, next_s2, below_s2, hs_s2, pf_one_s2, flat_s2;
	stcf_pkg::kind_t     kind_s2;
	logic signed [24:0]  cfd1_s2, cfd2_s2;
	logic [22:0]         tc100_s2, tn100_s2, fo100_s2;
	logic [30:0]         ps_s2;
	logic [15:0]         pa_s2, pb_s2, pc_s2;
	logic [23:0]         d_s2, u_s2, dmu_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			kind_s2   <= kind_s1;
			first_s2  <= first_s1;
			next_s2   <= next_s1;
			below_s2  <= below_c;
			hs_s2     <= hs_s1;
			cfd1_s2   <= cfd1_c;
			cfd2_s2   <= cfd2_c;
			tc100_s2  <= tc100_c;
			tn100_s2  <= tn100_c;
			fo100_s2  <= fo100_c;
			ps_s2     <= ps_c;
			pf_one_s2 <= !(sel_a || sel_b) || (sel_a && !den_pos);
			flat_s2   <= sel_b && !den_pos;
			pa_s2     <= sel_a ? ppv : pcv;
			pb_s2     <= sel_a ? pcv : pnv;
			pc_s2     <= pcv;
			d_s2      <= d_c;
			u_s2      <= u_c;
			dmu_s2    <= d_c - u_c;
		end
	end

	// ---------------- stage 3: fade points, pitch products ----------------
	logic signed [25:0] xi, xn;
	logic signed [35:0] sxi, sxn, ps_w, fo_w, gnum_c;
	logic signed [24:0] gden_c;
	logic act_c, g_full_c, g_inv_c;

	always_comb begin
		xi   = first_s2 ? $signed({3'b000, tc100_s2})
			: $signed({3'b000, tc100_s2}) - 26'(cfd1_s2);
		xn   = $signed({3'b000, tn100_s2}) - 26'(cfd2_s2);
		sxi  = $signed({{2{xi[25]}}, xi, 8'h00});
		sxn  = $signed({{2{xn[25]}}, xn, 8'h00});
		ps_w = $signed({5'b00000, ps_s2});
		fo_w = $signed({5'b00000, fo100_s2, 8'h00});
		act_c = hs_s2 && (sxi <= ps_w) && (ps_w < fo_w);

		g_full_c = 1'b1;
		g_inv_c  = 1'b0;
		gnum_c   = ps_w - sxi;
		gden_c   = cfd1_s2;
		if (cf != 7'd0) begin
			if (!first_s2 && below_s2) begin
				g_full_c = 1'b0;
			end else if (next_s2 && ps_w > sxn) begin
				g_full_c = 1'b0;
				g_inv_c  = 1'b1;
				gnum_c   = ps_w - sxn;
				gden_c   = cfd2_s2;
			end
		end
	end

	logic                vld_s3, act_s3, pf_one_s3, flat_s3, g_full_s3, g_inv_s3;
	stcf_pkg::kind_t     kind_s3;
	logic [15:0]         pb_s3, pc_s3;
	logic [39:0]         m1_s3, m2_s3, m3_s3;
	logic signed [35:0]  gnum_s3;
	logic signed [24:0]  gden_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			kind_s3   <= kind_s2;
			act_s3    <= act_c;
			pf_one_s3 <= pf_one_s2;
			flat_s3   <= flat_s2;
			g_full_s3 <= g_full_c;
			g_inv_s3  <= g_inv_c;
			pb_s3     <= pb_s2;
			pc_s3     <= pc_s2;
			m1_s3     <= 40'(pa_s2) * 40'(dmu_s2);
			m2_s3     <= 40'(pb_s2) * 40'(u_s2);
			m3_s3     <= 40'(pc_s2) * 40'(d_s2);
			gnum_s3   <= gnum_c;
			gden_s3   <= gden_c;
		end
	end

	// ---------------- stage 4: divider operands ----------------
	logic [40:0]        sum_c;
	logic [55:0]        np_c;
	logic [39:0]        dp_c;
	logic               sat_c;
	stcf_pkg::frac_t    frac_c;
	logic signed [35:0] gden_w;
	stcf_pkg::side_t    side_c;

	always_comb begin
		sum_c  = 41'(m1_s3) + 41'(m2_s3);
		np_c   = flat_s3 ? 56'({pb_s3, 16'h0000}) : {sum_c[39:0], 16'h0000};
		dp_c   = flat_s3 ? 40'(pc_s3) : m3_s3;
		sat_c  = 64'(np_c) >= {dp_c, 24'h000000};
		gden_w = $signed({{3{gden_s3[24]}}, gden_s3, 8'h00});
		if (gden_s3 <= 25'sd0) begin
			frac_c = stcf_pkg::FR_ONE;
		end else if (gnum_s3 <= 36'sd0) begin
			frac_c = stcf_pkg::FR_ZERO;
		end else if (gnum_s3 >= gden_w) begin
			frac_c = stcf_pkg::FR_ONE;
		end else begin
			frac_c = stcf_pkg::FR_DIV;
		end
		side_c.kind   = kind_s3;
		side_c.act    = act_s3;
		side_c.pf_one = pf_one_s3;
		side_c.pf_sat = sat_c;
		side_c.g_full = g_full_s3;
		side_c.g_inv  = g_inv_s3;
		side_c.frac   = frac_c;
	end

	logic               vld_s4;
	logic [55:0]        np_s4;
	logic [39:0]        dp_s4;
	logic [38:0]        ng_s4;
	logic [22:0]        dg_s4;
	stcf_pkg::side_t    side_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else if (en) begin
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			np_s4   <= np_c;
			dp_s4   <= dp_c;
			ng_s4   <= {gnum_s3[30:0], 8'h00};
			dg_s4   <= gden_s3[22:0];
			side_s4 <= side_c;
		end
	end

	// ---------------- dividers ----------------
	logic            pv_out, gv_out;
	logic [QW-1:0]   pq, gq;
	stcf_pkg::side_t side_d [QW];

	stcf_div #(.NUM_W(56), .DEN_W(40), .Q_W(QW)) u_pdiv (
		.clk(clk), .arst_n(arst_n), .en(en), .vld_in(vld_s4),
		.num(np_s4), .den(dp_s4), .vld_out(pv_out), .quo(pq)
	);

	stcf_div #(.NUM_W(39), .DEN_W(23), .Q_W(QW)) u_gdiv (
		.clk(clk), .arst_n(arst_n), .en(en), .vld_in(vld_s4),
		.num(ng_s4), .den(dg_s4), .vld_out(gv_out), .quo(gq)
	);

	always_ff @(posedge clk) begin
		if (en) begin
			side_d[0] <= side_s4;
			for (int i = 1; i < QW; i++) begin
				side_d[i] <= side_d[i-1];
			end
		end
	end

	// ---------------- result register ----------------
	stcf_pkg::side_t sd;
	logic        act_o;
	logic [23:0] pf_o;
	logic [16:0] frac_v, gain_o;

	assign sd = side_d[QW-1];

	always_comb begin
		case (sd.frac)
			stcf_pkg::FR_ONE:  frac_v = stcf_pkg::ONE_Q16;
			stcf_pkg::FR_ZERO: frac_v = '0;
			default:           frac_v = {1'b0, gq[15:0]};
		endcase

		act_o  = 1'b0;
		pf_o   = 24'(stcf_pkg::ONE_Q16);
		gain_o = stcf_pkg::ONE_Q16;
		case (sd.kind)
			stcf_pkg::K_WRITE: begin
				pf_o   = '0;
				gain_o = '0;
			end
			stcf_pkg::K_BOOKEND: begin
			end
			stcf_pkg::K_OUTSIDE: begin
				gain_o = '0;
			end
			default: begin
				act_o = sd.act;
				if (!sd.pf_one) begin
					pf_o = sd.pf_sat ? stcf_pkg::PITCH_SAT : pq[23:0];
				end
				if (!sd.g_full) begin
					gain_o = sd.g_inv ? stcf_pkg::ONE_Q16 - frac_v : frac_v;
				end
			end
		endcase
	end

	logic        out_vld_q, active_q;
	logic [23:0] pf_q;
	logic [16:0] gain_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (en) begin
			out_vld_q <= pv_out && gv_out;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			active_q <= act_o;
			pf_q     <= pf_o;
			gain_q   <= gain_o;
		end
	end

	assign results.valid        = out_vld_q;
	assign results.active       = active_q;
	assign results.pitch_factor = pf_q;
	assign results.gain_factor  = gain_q;

endmodule

`default_nettype wire

@@ tb/sv/sample_table_crossfade_top_tb.sv @@
// Self-checking testbench for the sample table crossfade block.
`timescale 1ns / 1ps

module sample_table_crossfade_top_tb;

	localparam logic OP_EVAL = 1'b1;
	localparam int   NCH     = stcf_pkg::MAX_CHUNKS_DEF;
	localparam longint FADE_SCALE = 25600;

	typedef struct {
		logic        op;
		logic [3:0]  idx;
		logic [15:0] thr;
		logic [15:0] pitch;
		logic        has;
		logic        bookend;
		logic [31:0] cv;
	} item_word_t;

	typedef struct {
		logic        active;
		logic [23:0] pitch;
		logic [16:0] gain;
	} result_word_t;

	typedef struct {
		bit           is_cfg;
		logic [1:0]   reg_idx;
		logic [15:0]  reg_val;
		item_word_t   w;
		bit           typed;
		result_word_t res;
	} stim_row_t;

	logic clk;
	logic arst_n;
	stcf_item_if   items_ch ();
	stcf_result_if res_ch ();
	stcf_cfg_if    cfg_ch ();

	sample_table_crossfade_top uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.items   (items_ch),
		.results (res_ch),
		.cfg     (cfg_ch)
	);

	// table and register copy
	logic [15:0] tbl_thr [NCH];
	logic [15:0] tbl_pitch [NCH];
	logic        tbl_has [NCH];
	logic [6:0]  xfade_reg;
	logic [4:0]  count_reg;
	logic [15:0] floor_reg;

	result_word_t pending_results [$];
	bit fail_seen;
	bit quiet;
	int rx_hold;

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	initial begin
		#30_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

	function automatic int live_count();
		if (count_reg == 0) return 1;
		if (count_reg > NCH) return NCH;
		return count_reg;
	endfunction

	function automatic longint pitch_eff(int i);
		return (tbl_pitch[i] == 0) ? longint'(stcf_pkg::PITCH_ONE) : longint'(tbl_pitch[i]);
	endfunction

	function automatic longint fadein_pt(int i, longint cf);
		if (i == 0) return longint'(tbl_thr[0]) * FADE_SCALE;
		return longint'(tbl_thr[i]) * FADE_SCALE
			- cf * (longint'(tbl_thr[i]) - longint'(tbl_thr[i-1])) * 256;
	endfunction

	function automatic longint fadeout_pt(int i, int n);
		longint t;
		if (i + 1 < n) return longint'(tbl_thr[i+1]) * FADE_SCALE;
		t = tbl_thr[i];
		if (longint'(floor_reg) > t) t = floor_reg;
		return t * FADE_SCALE;
	endfunction

	function automatic logic [23:0] pitch_blend(longint pa, longint pb, longint pc,
			longint num, longint den);
		longint r;
		if (den <= 0) begin
			r = (65536 * pb) / pc;
		end else begin
			if (num < 0) num = 0;
			if (num > den) num = den;
			r = (65536 * (pa * (den - num) + pb * num)) / (pc * den);
		end
		return (r > longint'(stcf_pkg::PITCH_SAT)) ? stcf_pkg::PITCH_SAT : r[23:0];
	endfunction

	function automatic longint frac_q16(longint num, longint den);
		if (den <= 0) return 65536;
		if (num <= 0) return 0;
		if (num >= den) return 65536;
		return (num * 65536) / den;
	endfunction

	function automatic longint point_of(logic [31:0] raw);
		longint c;
		longint p;
		c = longint'($signed(raw));
		if (c <= 0) return 0;
		p = (c * 100) >>> 8;
		if (c <= 65536) begin
			return (p > longint'(stcf_pkg::PT_CAP_LOW)) ? longint'(stcf_pkg::PT_CAP_LOW) : p;
		end
		return (p > longint'(stcf_pkg::PT_MAX)) ? longint'(stcf_pkg::PT_MAX) : p;
	endfunction

	// expected result of one accepted word; writes update the table copy
	function automatic result_word_t crossfade_result(item_word_t w);
		result_word_t r;
		int i;
		int n;
		longint cf, p8, ps, t8, pc, fi, st, g;
		i = w.idx;
		r = '{1'b0, 24'd0, 17'd0};
		if (w.op == stcf_pkg::OP_WRITE) begin
			tbl_thr[i] = w.thr;
			tbl_pitch[i] = w.pitch;
			tbl_has[i] = w.has;
			return r;
		end
		if (w.bookend) return '{1'b0, 24'd65536, stcf_pkg::ONE_Q16};
		n = live_count();
		if (i >= n) return '{1'b0, 24'd65536, 17'd0};
		cf = (xfade_reg > stcf_pkg::CF_MAX) ? 100 : xfade_reg;
		p8 = point_of(w.cv);
		ps = p8 * 100;
		t8 = longint'(tbl_thr[i]) * 256;
		pc = pitch_eff(i);
		r.active = tbl_has[i] && fadein_pt(i, cf) <= ps && ps < fadeout_pt(i, n);
		if (p8 < t8) begin
			if (i > 0)
				r.pitch = pitch_blend(pitch_eff(i-1), pc, pc, p8 - longint'(tbl_thr[i-1]) * 256,
					t8 - longint'(tbl_thr[i-1]) * 256);
			else
				r.pitch = 24'd65536;
		end else if (i + 1 < n) begin
			r.pitch = pitch_blend(pc, pitch_eff(i+1), pc, p8 - t8,
				longint'(tbl_thr[i+1]) * 256 - t8);
		end else begin
			r.pitch = 24'd65536;
		end
		g = 65536;
		if (cf != 0) begin
			if (i > 0 && p8 < t8) begin
				fi = fadein_pt(i, cf);
				g = frac_q16(ps - fi, longint'(tbl_thr[i]) * FADE_SCALE - fi);
			end else if (i + 1 < n) begin
				st = fadein_pt(i + 1, cf);
				if (ps > st) g = 65536 - frac_q16(ps - st, longint'(tbl_thr[i+1]) * FADE_SCALE - st);
			end
		end
		r.gain = g[16:0];
		return r;
	endfunction

	// result side: random backpressure, compare against oldest expectation
	always @(posedge clk) begin
		if (quiet) begin
			res_ch.ready <= 1'b1;
		end else if (rx_hold > 0) begin
			rx_hold <= rx_hold - 1;
			res_ch.ready <= 1'b0;
		end else if ($urandom_range(0, 99) < 80) begin
			res_ch.ready <= 1'b1;
		end else begin
			rx_hold <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
			res_ch.ready <= 1'b0;
		end
	end

	always @(posedge clk) begin
		result_word_t e;
		if (arst_n && res_ch.valid && res_ch.ready) begin
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result word active %0h pitch %0h gain %0h", $realtime,
					res_ch.active, res_ch.pitch_factor, res_ch.gain_factor);
				fail_seen = 1'b1;
			end else begin
				e = pending_results.pop_front();
				if (res_ch.active !== e.active) begin
					$display("%0t: active exp %0h got %0h", $realtime, e.active, res_ch.active);
					fail_seen = 1'b1;
				end
				if (res_ch.pitch_factor !== e.pitch) begin
					$display("%0t: pitch_factor exp %0h got %0h", $realtime, e.pitch,
						res_ch.pitch_factor);
					fail_seen = 1'b1;
				end
				if (res_ch.gain_factor !== e.gain) begin
					$display("%0t: gain_factor exp %0h got %0h", $realtime, e.gain,
						res_ch.gain_factor);
					fail_seen = 1'b1;
				end
			end
		end
	end

	task automatic sender_gap();
		int g;
		int r;
		g = 0;
		r = $urandom_range(0, 99);
		if (!quiet) begin
			if (r >= 95) g = $urandom_range(10, 40);
			else if (r >= 70) g = $urandom_range(1, 3);
		end
		if (g > 0) begin
			items_ch.valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
	endtask

	task automatic send_word(item_word_t w, bit typed, result_word_t exp_w);
		result_word_t pr;
		items_ch.valid <= 1'b1;
		items_ch.op <= w.op;
		items_ch.chunk_index <= w.idx;
		items_ch.threshold <= w.thr;
		items_ch.chunk_pitch <= w.pitch;
		items_ch.has_sample <= w.has;
		items_ch.is_bookend <= w.bookend;
		items_ch.control_value <= w.cv;
		do @(posedge clk); while (!items_ch.ready);
		pr = crossfade_result(w);
		pending_results.push_back(typed ? exp_w : pr);
		sender_gap();
	endtask

	task automatic drain();
		while (pending_results.size() != 0) @(posedge clk);
	endtask

	// register write, only with the pipeline empty
	task automatic write_reg(logic [1:0] ri, logic [15:0] val);
		items_ch.valid <= 1'b0;
		drain();
		@(posedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= ri;
		cfg_ch.data <= val;
		do @(posedge clk); while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
		case (ri)
			stcf_pkg::CFG_CROSSFADE: xfade_reg = val[6:0];
			stcf_pkg::CFG_COUNT:     count_reg = val[4:0];
			stcf_pkg::CFG_FLOOR:     floor_reg = val;
			default: ;
		endcase
	endtask

	function automatic stim_row_t mk_write(int i, int t, int pt, bit h);
		stim_row_t s;
		s = '{0, stcf_pkg::CFG_CROSSFADE, 16'd0,
			'{stcf_pkg::OP_WRITE, 4'(i), 16'(t), 16'(pt), h, 1'b0, 32'd0},
			1, '{1'b0, 24'd0, 17'd0}};
		return s;
	endfunction

	function automatic stim_row_t mk_eval(int i, logic [31:0] c, bit bk);
		stim_row_t s;
		s = '{0, stcf_pkg::CFG_CROSSFADE, 16'd0,
			'{OP_EVAL, 4'(i), 16'hFFFF, 16'hFFFF, 1'b1, bk, c},
			0, '{1'b0, 24'd0, 17'd0}};
		return s;
	endfunction

	function automatic stim_row_t mk_cfg(logic [1:0] ri, int val);
		stim_row_t s;
		s = '{1, ri, 16'(val), '{stcf_pkg::OP_WRITE, 4'd0, 16'd0, 16'd0, 1'b0, 1'b0, 32'd0},
			0, '{1'b0, 24'd0, 17'd0}};
		return s;
	endfunction

	function automatic stim_row_t with_result(stim_row_t s, logic a, int p, int g);
		s.typed = 1;
		s.res = '{a, 24'(p), 17'(g)};
		return s;
	endfunction

	function automatic logic [31:0] pick_control(int n);
		int j, lo, hi, mode;
		longint pt, c;
		mode = $urandom_range(0, 9);
		if (mode == 0) return $urandom;
		if (mode == 1) return $urandom_range(0, 70000);
		j = $urandom_range(0, n - 1);
		lo = (j > 0) ? j - 1 : 0;
		hi = (j + 1 < n) ? j + 1 : j;
		pt = longint'(tbl_thr[lo]) * 256 - 256
			+ longint'($urandom_range(0, (int'(tbl_thr[hi]) - int'(tbl_thr[lo])) * 256 + 1024));
		c = pt * 256 / 100 + $urandom_range(0, 3);
		if (c > 64'sh7FFFFFFF) c = 64'sh7FFFFFFF;
		return c[31:0];
	endfunction

	task automatic refill_table();
		int t;
		int step_max;
		result_word_t none;
		item_word_t w;
		none = '{1'b0, 24'd0, 17'd0};
		t = $urandom_range(0, 2000);
		step_max = ($urandom_range(0, 3) == 0) ? 8000 : 600;
		for (int i = 0; i < NCH; i++) begin
			w.op = stcf_pkg::OP_WRITE;
			w.idx = 4'(i);
			w.thr = (t > 65535) ? 16'hFFFF : 16'(t);
			w.pitch = ($urandom_range(0, 15) == 0) ? 16'd0 :
				($urandom_range(0, 3) == 0) ? 16'($urandom_range(1, 65535)) :
				16'($urandom_range(2048, 8192));
			w.has = ($urandom_range(0, 7) != 0);
			w.bookend = 1'($urandom);
			w.cv = $urandom;
			send_word(w, 0, none);
			t += ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, step_max);
		end
	endtask

	initial begin
		stim_row_t rows [$];
		stim_row_t s;
		item_word_t w;
		result_word_t none;
		int n;
		int r;

		arst_n = 1'b0;
		quiet = 1'b0;
		rx_hold = 0;
		fail_seen = 1'b0;
		res_ch.ready = 1'b0;
		items_ch.valid = 1'b0;
		items_ch.op = stcf_pkg::OP_WRITE;
		items_ch.chunk_index = '0;
		items_ch.threshold = '0;
		items_ch.chunk_pitch = '0;
		items_ch.has_sample = 1'b0;
		items_ch.is_bookend = 1'b0;
		items_ch.control_value = '0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = stcf_pkg::CFG_CROSSFADE;
		cfg_ch.data = '0;
		xfade_reg = 7'd0;
		count_reg = 5'd1;
		floor_reg = 16'd0;
		for (int i = 0; i < NCH; i++) begin
			tbl_has[i] = 1'b0;
			tbl_thr[i] = 'x;
			tbl_pitch[i] = 'x;
		end
		none = '{1'b0, 24'd0, 17'd0};

		rows.push_back(with_result(mk_eval(0, 32'h0001_0000, 1), 0, 65536, 65536));
		rows.push_back(with_result(mk_eval(3, 32'h0001_0000, 0), 0, 65536, 0));
		// fill: equal thresholds at 6/7, zero pitch at 2, no sample at 4, top at 15
		for (int i = 0; i < NCH; i++)
			rows.push_back(mk_write(i, (i == 15) ? 65535 : (i == 7) ? 60 : i * 10,
				(i == 2) ? 0 : (i == 9) ? 65535 : 4096 + i * 256, i != 4));
		rows.push_back(mk_cfg(stcf_pkg::CFG_CROSSFADE, 100));
		rows.push_back(mk_cfg(stcf_pkg::CFG_COUNT, 16));
		rows.push_back(mk_cfg(stcf_pkg::CFG_FLOOR, 65535));
		rows.push_back(mk_eval(0, 32'h8000_0000, 0));
		rows.push_back(mk_eval(7, 32'h7FFF_FFFF, 0));
		rows.push_back(mk_eval(3, 32'h0001_0000, 0));
		rows.push_back(mk_eval(10, 32'h0001_0001, 0));
		rows.push_back(mk_eval(15, 32'h7FFF_FFFF, 0));
		rows.push_back(mk_cfg(stcf_pkg::CFG_CROSSFADE, 127));
		rows.push_back(mk_cfg(stcf_pkg::CFG_COUNT, 0));
		rows.push_back(mk_eval(0, 32'h0000_8000, 0));
		rows.push_back(with_result(mk_eval(1, 32'h0000_8000, 0), 0, 65536, 0));

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (rows[k]) begin
			s = rows[k];
			if (s.is_cfg) write_reg(s.reg_idx, s.reg_val);
			else send_word(s.w, s.typed, s.res);
		end

		for (int ph = 0; ph < 8; ph++) begin
			quiet = (ph == 3);
			r = $urandom_range(0, 3);
			write_reg(stcf_pkg::CFG_CROSSFADE, (r == 0) ? 0 : (r == 1) ? 100 : (r == 2) ? 127 :
				$urandom_range(1, 99));
			r = $urandom_range(0, 4);
			write_reg(stcf_pkg::CFG_COUNT, (r == 0) ? 31 : (r == 1) ? 1 : (r == 2) ? 16 :
				$urandom_range(0, 16));
			r = $urandom_range(0, 3);
			write_reg(stcf_pkg::CFG_FLOOR, (r == 0) ? 0 : (r == 1) ? 65535 :
				$urandom_range(0, 65535));
			if (ph == 0 || $urandom_range(0, 9) < 7) refill_table();
			n = live_count();
			for (int k = 0; k < 205; k++) begin
				r = $urandom_range(0, 99);
				w.thr = 16'($urandom);
				w.pitch = 16'($urandom);
				w.has = 1'($urandom);
				w.bookend = 1'b0;
				w.cv = pick_control(n);
				w.idx = 4'($urandom_range(0, n - 1));
				w.op = OP_EVAL;
				if (r < 6) begin
					// stray write, possibly out of order
					w.op = stcf_pkg::OP_WRITE;
					w.idx = 4'($urandom);
					w.bookend = 1'($urandom);
				end else if (r < 11) begin
					w.bookend = 1'b1;
					w.idx = 4'($urandom);
				end else if (r < 16) begin
					w.idx = 4'($urandom);
				end
				send_word(w, 0, none);
			end
		end

		items_ch.valid <= 1'b0;
		drain();
		repeat (40) @(posedge clk);
		if (!fail_seen) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule

@@ files.f @@
hw/rtl/stcf_pkg.sv
hw/rtl/stcf_if.sv
hw/rtl/stcf_front.sv
hw/rtl/stcf_fifo.sv
hw/rtl/stcf_div.sv
hw/rtl/stcf_back.sv
hw/rtl/sample_table_crossfade_top.sv
tb/sv/sample_table_crossfade_top_tb.sv
